@@ hw/rtl/mp2d_pkg.sv @@
// ============================================================================
// mp2d_pkg: shared types, constants and helpers for the 2-D max pooling block
// Register codes, geometry and window tag structs, and the register clamp.
// ============================================================================
`default_nettype none

package mp2d_pkg;

  // Default sizing of the top level
  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_HEIGHT   = 1024;
  localparam int DEF_MAX_CHANNELS = 1024;
  localparam int DEF_MAX_KERNEL   = 8;
  localparam int DEF_SAMPLE_BITS  = 16;

  // Register file layout
  localparam int REG_WIDE_W   = 11;
  localparam int REG_NARROW_W = 4;
  localparam int CFG_INDEX_W  = 3;
  localparam int OUT_IDX_W    = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_HEIGHT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_X        = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_Y        = 3'd6;

  // Register reset values
  localparam int RST_MAP_WIDTH     = 8;
  localparam int RST_MAP_HEIGHT    = 8;
  localparam int RST_CHANNEL_COUNT = 1;
  localparam int RST_KERNEL        = 2;
  localparam int RST_STEP          = 2;

  // Output queue sizing
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

  // Clamped geometry as seen by the datapath
  typedef struct packed {
    logic [REG_WIDE_W-1:0]   map_width;
    logic [REG_WIDE_W-1:0]   map_height;
    logic [REG_WIDE_W-1:0]   channel_count;
    logic [REG_NARROW_W-1:0] kernel_width;
    logic [REG_NARROW_W-1:0] kernel_height;
    logic [REG_NARROW_W-1:0] step_x;
    logic [REG_NARROW_W-1:0] step_y;
  } geom_t;

  // Position of one finished window
  typedef struct packed {
    logic                 last_window;
    logic [OUT_IDX_W-1:0] channel_index;
    logic [OUT_IDX_W-1:0] out_row;
    logic [OUT_IDX_W-1:0] out_col;
  } win_meta_t;

  // Tag carried with each sample down the pipe
  typedef struct packed {
    logic      emit;
    win_meta_t meta;
  } item_tag_t;

  // Zero reads as one, anything above the limit saturates to it
  function automatic logic [REG_WIDE_W-1:0] clamp_reg(input logic [REG_WIDE_W-1:0] v,
                                                     input int unsigned hi);
    logic [REG_WIDE_W-1:0] res;
    if (v == '0) begin
      res = REG_WIDE_W'(1);
    end else if (32'(v) > hi) begin
      res = REG_WIDE_W'(hi);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mp2d_cfg.sv @@
// ============================================================================
// mp2d_cfg: configuration registers
// Holds the clamped geometry and flags a restart of the position counters.
// ============================================================================
`default_nettype none

module mp2d_cfg #(
  parameter int MAX_WIDTH    = mp2d_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = mp2d_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = mp2d_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_KERNEL   = mp2d_pkg::DEF_MAX_KERNEL
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mp2d_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [mp2d_pkg::REG_WIDE_W-1:0]  cfg_data,
  output mp2d_pkg::geom_t                       geom,
  output logic                                  restart
);

  logic                                  wr;
  logic                                  idx_known;
  logic [mp2d_pkg::REG_WIDE_W-1:0]       narrow_in;
  logic [mp2d_pkg::REG_NARROW_W-1:0]     narrow_val;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Kernel and step registers keep only their low bits
  assign narrow_in  = mp2d_pkg::REG_WIDE_W'(cfg_data[mp2d_pkg::REG_NARROW_W-1:0]);
  assign narrow_val = mp2d_pkg::REG_NARROW_W'(mp2d_pkg::clamp_reg(narrow_in, MAX_KERNEL));

  // Only a write to a known register restarts the counters
  always_comb begin
    case (cfg_index)
      mp2d_pkg::REG_MAP_WIDTH,
      mp2d_pkg::REG_MAP_HEIGHT,
      mp2d_pkg::REG_CHANNEL_COUNT,
      mp2d_pkg::REG_KERNEL_WIDTH,
      mp2d_pkg::REG_KERNEL_HEIGHT,
      mp2d_pkg::REG_STEP_X,
      mp2d_pkg::REG_STEP_Y: idx_known = 1'b1;
      default:              idx_known = 1'b0;
    endcase
  end

  assign restart = wr && idx_known;

  // Register file, stored already clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.map_width     <= mp2d_pkg::clamp_reg(
                              mp2d_pkg::REG_WIDE_W'(mp2d_pkg::RST_MAP_WIDTH), MAX_WIDTH);
      geom.map_height    <= mp2d_pkg::clamp_reg(
                              mp2d_pkg::REG_WIDE_W'(mp2d_pkg::RST_MAP_HEIGHT), MAX_HEIGHT);
      geom.channel_count <= mp2d_pkg::clamp_reg(
                              mp2d_pkg::REG_WIDE_W'(mp2d_pkg::RST_CHANNEL_COUNT), MAX_CHANNELS);
      geom.kernel_width  <= mp2d_pkg::REG_NARROW_W'(mp2d_pkg::clamp_reg(
                              mp2d_pkg::REG_WIDE_W'(mp2d_pkg::RST_KERNEL), MAX_KERNEL));
      geom.kernel_height <= mp2d_pkg::REG_NARROW_W'(mp2d_pkg::clamp_reg(
                              mp2d_pkg::REG_WIDE_W'(mp2d_pkg::RST_KERNEL), MAX_KERNEL));
      geom.step_x        <= mp2d_pkg::REG_NARROW_W'(mp2d_pkg::clamp_reg(
                              mp2d_pkg::REG_WIDE_W'(mp2d_pkg::RST_STEP), MAX_KERNEL));
      geom.step_y        <= mp2d_pkg::REG_NARROW_W'(mp2d_pkg::clamp_reg(
                              mp2d_pkg::REG_WIDE_W'(mp2d_pkg::RST_STEP), MAX_KERNEL));
    end else if (wr) begin
      case (cfg_index)
        mp2d_pkg::REG_MAP_WIDTH:
          geom.map_width <= mp2d_pkg::clamp_reg(cfg_data, MAX_WIDTH);
        mp2d_pkg::REG_MAP_HEIGHT:
          geom.map_height <= mp2d_pkg::clamp_reg(cfg_data, MAX_HEIGHT);
        mp2d_pkg::REG_CHANNEL_COUNT:
          geom.channel_count <= mp2d_pkg::clamp_reg(cfg_data, MAX_CHANNELS);
        mp2d_pkg::REG_KERNEL_WIDTH:  geom.kernel_width  <= narrow_val;
        mp2d_pkg::REG_KERNEL_HEIGHT: geom.kernel_height <= narrow_val;
        mp2d_pkg::REG_STEP_X:        geom.step_x        <= narrow_val;
        mp2d_pkg::REG_STEP_Y:        geom.step_y        <= narrow_val;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mp2d_ctl.sv @@
// ============================================================================
// mp2d_ctl: raster position and window origin tracking
// Decides per sample whether it closes a window and where that window sits.
// ============================================================================
`default_nettype none

module mp2d_ctl #(
  parameter int MAX_WIDTH    = mp2d_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = mp2d_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = mp2d_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_KERNEL   = mp2d_pkg::DEF_MAX_KERNEL,
  localparam int AW          = $clog2(MAX_WIDTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mp2d_pkg::geom_t      geom,
  input  wire logic                 restart,
  input  wire logic                 accept,
  output logic [AW-1:0]             item_col,
  output mp2d_pkg::item_tag_t       item_tag
);

  localparam int AH  = $clog2(MAX_HEIGHT);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int OW  = $clog2(MAX_WIDTH + 2 * MAX_KERNEL);
  localparam int OH  = $clog2(MAX_HEIGHT + 2 * MAX_KERNEL);
  localparam int XW  = OW + 2;
  localparam int YW  = OH + 2;
  localparam int NW  = $clog2(MAX_CHANNELS + 1) + 1;
  localparam int IW  = mp2d_pkg::OUT_IDX_W;

  logic [AW-1:0]  col,      col_next;
  logic [AH-1:0]  row,      row_next;
  logic [CHW-1:0] chan,     chan_next;
  logic [OW-1:0]  org_col,  org_col_next;
  logic [OH-1:0]  org_row,  org_row_next;
  logic [IW-1:0]  ocol,     ocol_next;
  logic [IW-1:0]  orow,     orow_next;

  logic col_done, row_done, wrap_c, wrap_r;
  logic last_c, last_r, last_ch;

  // Window and edge decisions for the current position
  assign col_done = (XW'(col) + 1'b1) == (XW'(org_col) + XW'(geom.kernel_width));
  assign row_done = (YW'(row) + 1'b1) == (YW'(org_row) + YW'(geom.kernel_height));
  assign wrap_c   = (XW'(col) + 1'b1) >= XW'(geom.map_width);
  assign wrap_r   = (YW'(row) + 1'b1) >= YW'(geom.map_height);
  assign last_c   = (XW'(org_col) + XW'(geom.step_x) + XW'(geom.kernel_width))
                    > XW'(geom.map_width);
  assign last_r   = (YW'(org_row) + YW'(geom.step_y) + YW'(geom.kernel_height))
                    > YW'(geom.map_height);
  assign last_ch  = (NW'(chan) + 1'b1) >= NW'(geom.channel_count);

  assign item_col                    = col;
  assign item_tag.emit               = col_done && row_done;
  assign item_tag.meta.out_col       = ocol;
  assign item_tag.meta.out_row       = orow;
  assign item_tag.meta.channel_index = IW'(chan);
  assign item_tag.meta.last_window   = last_c && last_r && last_ch;

  // Counter advance on each accepted sample
  always_comb begin
    col_next     = col;
    row_next     = row;
    chan_next    = chan;
    org_col_next = org_col;
    org_row_next = org_row;
    ocol_next    = ocol;
    orow_next    = orow;
    if (accept) begin
      if (col_done) begin
        org_col_next = org_col + OW'(geom.step_x);
        ocol_next    = ocol + 1'b1;
      end
      if (wrap_c) begin
        col_next     = '0;
        org_col_next = '0;
        ocol_next    = '0;
        if (row_done) begin
          org_row_next = org_row + OH'(geom.step_y);
          orow_next    = orow + 1'b1;
        end
        if (wrap_r) begin
          row_next     = '0;
          org_row_next = '0;
          orow_next    = '0;
          chan_next    = last_ch ? '0 : chan + 1'b1;
        end else begin
          row_next = row + 1'b1;
        end
      end else begin
        col_next = col + 1'b1;
      end
    end
  end

  // Position registers; a write to a known register starts over at the map origin
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col     <= '0;
      row     <= '0;
      chan    <= '0;
      org_col <= '0;
      org_row <= '0;
      ocol    <= '0;
      orow    <= '0;
    end else begin
      col     <= col_next;
      row     <= row_next;
      chan    <= chan_next;
      org_col <= org_col_next;
      org_row <= org_row_next;
      ocol    <= ocol_next;
      orow    <= orow_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mp2d_pool.sv @@
// ============================================================================
// mp2d_pool: line store and max datapath
// Column maximum over the kernel rows, then window maximum over the columns.
// ============================================================================
`default_nettype none

module mp2d_pool #(
  parameter int MAX_WIDTH   = mp2d_pkg::DEF_MAX_WIDTH,
  parameter int MAX_KERNEL  = mp2d_pkg::DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS,
  localparam int AW         = $clog2(MAX_WIDTH)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 accept,
  input  wire logic [SAMPLE_BITS-1:0]               sample,
  input  wire logic [AW-1:0]                        col,
  input  wire mp2d_pkg::item_tag_t                  tag,
  input  wire logic [mp2d_pkg::REG_NARROW_W-1:0]    kernel_width,
  input  wire logic [mp2d_pkg::REG_NARROW_W-1:0]    kernel_height,
  output logic                                      push,
  output logic [SAMPLE_BITS-1:0]                    push_value,
  output mp2d_pkg::win_meta_t                       push_meta,
  output logic [1:0]                                inflight
);

  localparam int NR = MAX_KERNEL - 1;

  // Line store: per column, the samples of the previous rows, newest first
  logic [NR-1:0][SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
  logic [NR-1:0][SAMPLE_BITS-1:0] rd_q;
  logic [NR-1:0][SAMPLE_BITS-1:0] byp_vec;
  logic [NR-1:0][SAMPLE_BITS-1:0] vec;
  logic [NR-1:0][SAMPLE_BITS-1:0] wvec;

  // Stage 1: sample with line store read
  logic                      s1_valid;
  logic                      s1_byp;
  logic [SAMPLE_BITS-1:0]    s1_sample;
  logic [AW-1:0]             s1_col;
  mp2d_pkg::item_tag_t       s1_tag;
  logic [SAMPLE_BITS-1:0]    colmax;

  // Stage 2: column maximum and recent column history
  logic                           s2_valid;
  logic [SAMPLE_BITS-1:0]         s2_colmax;
  mp2d_pkg::item_tag_t            s2_tag;
  logic [NR-1:0][SAMPLE_BITS-1:0] hist;
  logic [SAMPLE_BITS-1:0]         winmax;

  // Line store port: read on accept, write back from stage 1
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_mem[s1_col] <= wvec;
    end
    if (accept) begin
      rd_q <= line_mem[col];
    end
  end

  // Stage valids and the read-after-write bypass flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s1_byp   <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s1_byp   <= accept && s1_valid && (col == s1_col);
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    byp_vec <= wvec;
    if (accept) begin
      s1_sample <= sample;
      s1_col    <= col;
      s1_tag    <= tag;
    end
    if (s1_valid) begin
      s2_colmax <= colmax;
      s2_tag    <= s1_tag;
    end
    if (s2_valid) begin
      hist[0] <= s2_colmax;
      for (int j = 1; j < NR; j++) begin
        hist[j] <= hist[j-1];
      end
    end
  end

  // Column maximum over the kernel rows; shift the new sample into the column
  always_comb begin
    vec    = s1_byp ? byp_vec : rd_q;
    colmax = s1_sample;
    for (int j = 0; j < NR; j++) begin
      if ((j + 1) < int'(kernel_height) && $signed(vec[j]) > $signed(colmax)) begin
        colmax = vec[j];
      end
    end
    wvec[0] = s1_sample;
    for (int j = 1; j < NR; j++) begin
      wvec[j] = vec[j-1];
    end
  end

  // Window maximum over the last kernel_width column maxima
  always_comb begin
    winmax = s2_colmax;
    for (int j = 0; j < NR; j++) begin
      if ((j + 1) < int'(kernel_width) && $signed(hist[j]) > $signed(winmax)) begin
        winmax = hist[j];
      end
    end
  end

  assign push       = s2_valid && s2_tag.emit;
  assign push_value = winmax;
  assign push_meta  = s2_tag.meta;
  assign inflight   = 2'(s1_valid && s1_tag.emit) + 2'(s2_valid && s2_tag.emit);

endmodule

`default_nettype wire

@@ hw/rtl/mp2d_ofifo.sv @@
// ============================================================================
// mp2d_ofifo: result queue
// Small queue between the datapath and the output channel.
// ============================================================================
`default_nettype none

module mp2d_ofifo #(
  parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  input  wire logic [SAMPLE_BITS-1:0]            push_value,
  input  wire mp2d_pkg::win_meta_t               push_meta,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [SAMPLE_BITS-1:0]                 value,
  output mp2d_pkg::win_meta_t                    meta,
  output logic [mp2d_pkg::OFIFO_CNT_W-1:0]       count
);

  localparam int DEPTH = mp2d_pkg::OFIFO_DEPTH;
  localparam int PW    = mp2d_pkg::OFIFO_PTR_W;

  logic [SAMPLE_BITS-1:0] val_q  [DEPTH];
  mp2d_pkg::win_meta_t    meta_q [DEPTH];
  logic [PW-1:0]          wr_ptr, rd_ptr;
  logic                   pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign value     = val_q[rd_ptr];
  assign meta      = meta_q[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + mp2d_pkg::OFIFO_CNT_W'(push) - mp2d_pkg::OFIFO_CNT_W'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      val_q[wr_ptr]  <= push_value;
      meta_q[wr_ptr] <= push_meta;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/max_pool_2d_stream_top.sv @@
// ============================================================================
// max_pool_2d_stream_top: streaming 2-D max pooling
// Raster-order samples in, one window maximum out per completed window.
// ============================================================================
//
//   channel  handshake               payload
//   -------  ----------------------  ----------------------------------------
//   in       in_valid / in_stall     sample_value
//   out      out_valid / out_stall   pooled_value, out_col, out_row,
//                                    channel_index, last_window
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One sample is taken per clock while in_stall is low; the line store has one read
// and one write port per cycle, which sets that rate.
// A result passes stage 1, stage 2 and the result queue on its way to out_valid.
// The result queue holds four entries; input stalls only when queued and
// in-flight results fill it, so the input keeps moving while a result waits.
// Synchronous reset clears control state; the line store needs no clearing.
// ============================================================================
`default_nettype none

module max_pool_2d_stream_top #(
  parameter int MAX_WIDTH    = mp2d_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = mp2d_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = mp2d_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_KERNEL   = mp2d_pkg::DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS  = mp2d_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input samples
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]      sample_value,
  // pooled results
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]           pooled_value,
  output logic [mp2d_pkg::OUT_IDX_W-1:0]          out_col,
  output logic [mp2d_pkg::OUT_IDX_W-1:0]          out_row,
  output logic [mp2d_pkg::OUT_IDX_W-1:0]          channel_index,
  output logic                                    last_window,
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mp2d_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [mp2d_pkg::REG_WIDE_W-1:0]    cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PW = mp2d_pkg::OFIFO_CNT_W + 1;

  mp2d_pkg::geom_t                  geom;
  logic                             restart;
  logic                             accept;
  logic [AW-1:0]                    item_col;
  mp2d_pkg::item_tag_t              item_tag;
  logic                             push;
  logic [SAMPLE_BITS-1:0]           push_value;
  mp2d_pkg::win_meta_t              push_meta;
  logic [1:0]                       inflight;
  logic [mp2d_pkg::OFIFO_CNT_W-1:0] q_count;
  logic [SAMPLE_BITS-1:0]           q_value;
  mp2d_pkg::win_meta_t              q_meta;
  logic [PW-1:0]                    pending;

  // Stall when queued plus in-flight results could overrun the queue
  assign pending  = PW'(q_count) + PW'(inflight);
  assign in_stall = (32'(pending) >= mp2d_pkg::OFIFO_DEPTH);
  assign accept   = in_valid && !in_stall;

  mp2d_cfg #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_KERNEL   (MAX_KERNEL)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .restart   (restart)
  );

  mp2d_ctl #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_KERNEL   (MAX_KERNEL)
  ) u_ctl (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .restart  (restart),
    .accept   (accept),
    .item_col (item_col),
    .item_tag (item_tag)
  );

  mp2d_pool #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_KERNEL  (MAX_KERNEL),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_pool (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .sample        (sample_value),
    .col           (item_col),
    .tag           (item_tag),
    .kernel_width  (geom.kernel_width),
    .kernel_height (geom.kernel_height),
    .push          (push),
    .push_value    (push_value),
    .push_meta     (push_meta),
    .inflight      (inflight)
  );

  mp2d_ofifo #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ofifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_value (push_value),
    .push_meta  (push_meta),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (q_value),
    .meta       (q_meta),
    .count      (q_count)
  );

  assign pooled_value  = q_value;
  assign out_col       = q_meta.out_col;
  assign out_row       = q_meta.out_row;
  assign channel_index = q_meta.channel_index;
  assign last_window   = q_meta.last_window;

endmodule

`default_nettype wire

@@ hw/rtl/mp2d_check.sv @@
// ============================================================================
// mp2d_check: port-level checks for the max pooling block
// Watches the top level's channels over time; attached by bind.
// ============================================================================
`default_nettype none

module mp2d_check #(
  parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [SAMPLE_BITS-1:0]           pooled_value,
  input wire logic [mp2d_pkg::OUT_IDX_W-1:0]   out_col,
  input wire logic [mp2d_pkg::OUT_IDX_W-1:0]   out_row,
  input wire logic [mp2d_pkg::OUT_IDX_W-1:0]   channel_index,
  input wire logic                             last_window
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pooled_value) && $stable(out_col)
      && $stable(out_row) && $stable(channel_index) && $stable(last_window))
    else $error("stalled result changed");

  // Reset empties the result queue
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("queue not empty after reset");

  // Input only backs up behind results that are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // A fresh result comes from a sample accepted earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
    else $error("result without matching transaction");

endmodule

bind max_pool_2d_stream_top mp2d_check #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .pooled_value  (pooled_value),
  .out_col       (out_col),
  .out_row       (out_row),
  .channel_index (channel_index),
  .last_window   (last_window)
);

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb: testbench for the streaming 2-D max pooling block
// Streams raster-order feature maps through max_pool_2d_stream_top under many
// window geometries and handshake idling patterns. Each window result is
// compared field by field with a hand-written value or a behavioral model of
// the line store and window maxima. Directed rows go first, random maps last.
// ============================================================================

module tb;
  import mp2d_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int MAP_W_MAX     = DEF_MAX_WIDTH;
  localparam int MAP_H_MAX     = DEF_MAX_HEIGHT;
  localparam int CHAN_MAX      = DEF_MAX_CHANNELS;
  localparam int KERN_MAX      = DEF_MAX_KERNEL;
  localparam int LINE_ROWS     = DEF_MAX_KERNEL - 1;
  localparam int NUM_REGS      = 7;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 400;
  localparam int CYCLE_LIMIT   = 600000;

  // Index past the register list; writes to it are dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    logic [DEF_SAMPLE_BITS-1:0] value;
    logic [OUT_IDX_W-1:0]       col;
    logic [OUT_IDX_W-1:0]       row;
    logic [OUT_IDX_W-1:0]       chan;
    logic                       last;
  } pool_result_t;

  typedef struct {
    row_kind_t                  kind;
    logic [CFG_INDEX_W-1:0]     idx;
    logic [REG_WIDE_W-1:0]      data;
    logic [DEF_SAMPLE_BITS-1:0] sample;
    bit                         fixed;
    pool_result_t               want;
  } dir_row_t;

  // Clock and DUT signals
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DEF_SAMPLE_BITS-1:0] sample_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DEF_SAMPLE_BITS-1:0] pooled_value;
  logic [OUT_IDX_W-1:0] out_col;
  logic [OUT_IDX_W-1:0] out_row;
  logic [OUT_IDX_W-1:0] channel_index;
  logic last_window;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [REG_WIDE_W-1:0] cfg_data = '0;

  // Idling control
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Pooling model state
  logic [REG_WIDE_W-1:0] geom_regs [NUM_REGS];
  logic signed [DEF_SAMPLE_BITS-1:0] line_rows [LINE_ROWS][MAP_W_MAX];
  logic signed [DEF_SAMPLE_BITS-1:0] col_max_ring [KERN_MAX];
  int unsigned col_pos, row_pos, chan_pos, origin_col, origin_row;
  pool_result_t pooled_q[$];

  always #(CLK_HALF) clk = ~clk;

  max_pool_2d_stream_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_value  (sample_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pooled_value  (pooled_value),
    .out_col       (out_col),
    .out_row       (out_row),
    .channel_index (channel_index),
    .last_window   (last_window),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Pooling model
  // ---------------------------------------------------------------------------

  // Effective register value: zero reads as one, large values saturate
  function automatic int unsigned geom(input int i, input int unsigned hi);
    int unsigned v;
    v = geom_regs[i];
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void restart_positions();
    col_pos = 0;
    row_pos = 0;
    chan_pos = 0;
    origin_col = 0;
    origin_row = 0;
  endfunction

  function automatic void reset_model();
    geom_regs[REG_MAP_WIDTH]     = REG_WIDE_W'(RST_MAP_WIDTH);
    geom_regs[REG_MAP_HEIGHT]    = REG_WIDE_W'(RST_MAP_HEIGHT);
    geom_regs[REG_CHANNEL_COUNT] = REG_WIDE_W'(RST_CHANNEL_COUNT);
    geom_regs[REG_KERNEL_WIDTH]  = REG_WIDE_W'(RST_KERNEL);
    geom_regs[REG_KERNEL_HEIGHT] = REG_WIDE_W'(RST_KERNEL);
    geom_regs[REG_STEP_X]        = REG_WIDE_W'(RST_STEP);
    geom_regs[REG_STEP_Y]        = REG_WIDE_W'(RST_STEP);
    foreach (line_rows[i, j]) line_rows[i][j] = '0;
    foreach (col_max_ring[i]) col_max_ring[i] = '0;
    restart_positions();
  endfunction

  // Register write: narrow registers keep four bits, a write to a known index restarts
  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [REG_WIDE_W-1:0] data);
    if (idx >= NUM_REGS) return;
    if (idx <= REG_CHANNEL_COUNT) geom_regs[idx] = data;
    else geom_regs[idx] = data & REG_WIDE_W'(4'hF);
    restart_positions();
  endfunction

  // Sample count of one full map set at the current geometry
  function automatic int unsigned map_set_size();
    return geom(REG_MAP_WIDTH, MAP_W_MAX) * geom(REG_MAP_HEIGHT, MAP_H_MAX)
           * geom(REG_CHANNEL_COUNT, CHAN_MAX);
  endfunction

  // Advance by one sample; returns 1 when it closes a window
  function automatic bit pool_window(input logic signed [DEF_SAMPLE_BITS-1:0] s,
                                     output pool_result_t res);
    int unsigned w, h, nc, kw, kh, sx, sy, c, r, k, pr;
    logic signed [DEF_SAMPLE_BITS-1:0] cmax, wmax;
    bit col_done, row_done, made;
    w  = geom(REG_MAP_WIDTH, MAP_W_MAX);
    h  = geom(REG_MAP_HEIGHT, MAP_H_MAX);
    nc = geom(REG_CHANNEL_COUNT, CHAN_MAX);
    kw = geom(REG_KERNEL_WIDTH, KERN_MAX);
    kh = geom(REG_KERNEL_HEIGHT, KERN_MAX);
    sx = geom(REG_STEP_X, KERN_MAX);
    sy = geom(REG_STEP_Y, KERN_MAX);
    c = col_pos % MAP_W_MAX;
    r = row_pos;
    col_done = (c == origin_col + kw - 1);
    row_done = (r == origin_row + kh - 1);

    // column maximum over the kernel rows ending here
    cmax = s;
    for (k = 1; k < kh; k++) begin
      pr = (r + LINE_ROWS * KERN_MAX - k) % LINE_ROWS;
      if (line_rows[pr][c] > cmax) cmax = line_rows[pr][c];
    end
    col_max_ring[c % KERN_MAX] = cmax;
    line_rows[r % LINE_ROWS][c] = s;

    made = col_done && row_done;
    res = '0;
    if (made) begin
      wmax = cmax;
      for (k = 1; k < kw; k++) begin
        if (col_max_ring[(c + KERN_MAX - k) % KERN_MAX] > wmax)
          wmax = col_max_ring[(c + KERN_MAX - k) % KERN_MAX];
      end
      res.value = wmax;
      res.col   = OUT_IDX_W'(origin_col / sx);
      res.row   = OUT_IDX_W'(origin_row / sy);
      res.chan  = OUT_IDX_W'(chan_pos);
      res.last  = (origin_col + sx + kw > w) && (origin_row + sy + kh > h)
                  && (chan_pos + 1 >= nc);
    end

    // position update
    if (col_done) origin_col += sx;
    if (c + 1 >= w) begin
      col_pos = 0;
      origin_col = 0;
      if (row_done) origin_row += sy;
      if (r + 1 >= h) begin
        row_pos = 0;
        origin_row = 0;
        chan_pos++;
        if (chan_pos >= nc) chan_pos = 0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
    return made;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------

  function automatic dir_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [REG_WIDE_W-1:0] data);
    dir_row_t dr;
    dr.kind = ROW_CFG;
    dr.idx = idx;
    dr.data = data;
    dr.sample = '0;
    dr.fixed = 1'b0;
    dr.want = '0;
    return dr;
  endfunction

  function automatic dir_row_t smp_row(input logic [DEF_SAMPLE_BITS-1:0] v);
    dir_row_t dr;
    dr.kind = ROW_SAMPLE;
    dr.idx = '0;
    dr.data = '0;
    dr.sample = v;
    dr.fixed = 1'b0;
    dr.want = '0;
    return dr;
  endfunction

  // Sample row with its result written out by hand
  function automatic dir_row_t smp_row_want(input logic [DEF_SAMPLE_BITS-1:0] v,
                                            input logic [DEF_SAMPLE_BITS-1:0] mx,
                                            input int col, input int row,
                                            input int chan, input bit last);
    dir_row_t dr;
    dr = smp_row(v);
    dr.fixed = 1'b1;
    dr.want.value = mx;
    dr.want.col = OUT_IDX_W'(col);
    dr.want.row = OUT_IDX_W'(row);
    dr.want.chan = OUT_IDX_W'(chan);
    dr.want.last = last;
    return dr;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------------

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        gap_pct = 75;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;
        stall_pct = 75;
      end
      default: begin
        gap_pct = 19;
        stall_pct = 19;
      end
    endcase
  endtask

  // Offer one sample, wait for the transaction, then update the model
  task automatic send_sample(input logic [DEF_SAMPLE_BITS-1:0] v, input bit fixed,
                             input pool_result_t want);
    pool_result_t res;
    bit made;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    sample_value <= v;
    do @(posedge clk); while (in_stall);
    made = pool_window(v, res);
    if (fixed) pooled_q.push_back(want);
    else if (made) pooled_q.push_back(res);
  endtask

  // Wait until the block has nothing left in flight
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pooled_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Caller lowers cfg_valid after the last write of a batch
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [REG_WIDE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  task automatic reconfigure(input logic [REG_WIDE_W-1:0] w, input logic [REG_WIDE_W-1:0] h,
                             input logic [REG_WIDE_W-1:0] nc,
                             input logic [REG_WIDE_W-1:0] kw, input logic [REG_WIDE_W-1:0] kh,
                             input logic [REG_WIDE_W-1:0] sx, input logic [REG_WIDE_W-1:0] sy,
                             input bit poke_unused);
    settle();
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
    write_reg(REG_CHANNEL_COUNT, nc);
    write_reg(REG_KERNEL_WIDTH, kw);
    write_reg(REG_KERNEL_HEIGHT, kh);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    if (poke_unused) write_reg(REG_UNUSED, REG_WIDE_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Extremes now and then, otherwise any 16-bit pattern
  function automatic logic [DEF_SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return DEF_SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [REG_WIDE_W-1:0] pick_reg(input int unsigned lo,
                                                     input int unsigned hi,
                                                     input bit allow_top);
    case ($urandom_range(19))
      0: return '0;
      1: return allow_top ? 11'h7FF : REG_WIDE_W'(hi);
      default: return REG_WIDE_W'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic stream_samples(input int unsigned count, input bit pause_midway);
    for (int unsigned i = 0; i < count; i++) begin
      // halfway through, the sender waits for every pending result before going on
      if (pause_midway && i == count / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pooled_q.size() != 0);
      end
      send_sample(pick_sample(), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic check_pooled();
    pool_result_t want;
    if (pooled_q.size() == 0) begin
      report_mismatch("result with none pending", $unsigned(pooled_value), 0);
    end else begin
      want = pooled_q.pop_front();
      if (pooled_value !== want.value)
        report_mismatch("pooled_value", $unsigned(pooled_value), want.value);
      if (out_col !== want.col) report_mismatch("out_col", out_col, want.col);
      if (out_row !== want.row) report_mismatch("out_row", out_row, want.row);
      if (channel_index !== want.chan)
        report_mismatch("channel_index", channel_index, want.chan);
      if (last_window !== want.last)
        report_mismatch("last_window", last_window, want.last);
    end
  endtask

  // Receiver: check each transaction, then choose the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_pooled();
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t dir_rows[$];
    bit cfg_open;
    int unsigned phase, total, items, set_size, kmax;

    reset_model();
    set_idling(IDLE_NONE);

    dir_rows = '{
      // 2x2 map, two channels, 2x2 window at stride 2
      cfg_row(REG_MAP_WIDTH, 11'd2),
      cfg_row(REG_MAP_HEIGHT, 11'd2),
      cfg_row(REG_CHANNEL_COUNT, 11'd2),
      cfg_row(REG_KERNEL_WIDTH, 11'd2),
      cfg_row(REG_KERNEL_HEIGHT, 11'd2),
      cfg_row(REG_STEP_X, 11'd2),
      cfg_row(REG_STEP_Y, 11'd2),
      // all most-negative
      smp_row(16'h8000),
      smp_row(16'h8000),
      smp_row(16'h8000),
      smp_row_want(16'h8000, 16'h8000, 0, 0, 0, 1'b0),
      // maximum held in the line store, last window of the set
      smp_row(16'h7FFF),
      smp_row(16'h8000),
      smp_row(16'h8000),
      smp_row_want(16'h8000, 16'h7FFF, 0, 0, 1, 1'b1),
      smp_row(16'h5555),
      smp_row(16'hAAAA),
      smp_row(16'h00FF),
      smp_row(16'hFF00),
      // zero kernel and step registers read as one
      cfg_row(REG_KERNEL_WIDTH, 11'd0),
      cfg_row(REG_KERNEL_HEIGHT, 11'd0),
      cfg_row(REG_STEP_X, 11'd0),
      cfg_row(REG_STEP_Y, 11'd0),
      smp_row_want(16'h1234, 16'h1234, 0, 0, 0, 1'b0),
      smp_row_want(16'h8001, 16'h8001, 1, 0, 0, 1'b0),
      smp_row_want(16'h0000, 16'h0000, 0, 1, 0, 1'b0),
      smp_row_want(16'hFFFF, 16'hFFFF, 1, 1, 0, 1'b0),
      // index past the list: dropped, position carries on into channel 1
      cfg_row(REG_UNUSED, 11'h7FF),
      smp_row_want(16'h7FFF, 16'h7FFF, 0, 0, 1, 1'b0),
      // kernel saturates to 8, wider than the map: no windows
      cfg_row(REG_KERNEL_WIDTH, 11'h7FF),
      smp_row(16'h0001),
      smp_row(16'h0002),
      smp_row(16'h0003),
      // zero width reads as one column
      cfg_row(REG_MAP_WIDTH, 11'd0),
      cfg_row(REG_KERNEL_WIDTH, 11'd1),
      smp_row_want(16'h4000, 16'h4000, 0, 0, 0, 1'b0),
      smp_row_want(16'hC000, 16'hC000, 0, 1, 0, 1'b0)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    cfg_open = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!cfg_open) settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid <= 1'b0;
        cfg_open = 1'b0;
        send_sample(dir_rows[i].sample, dir_rows[i].fixed, dir_rows[i].want);
      end
    end

    // Long receiver hold while the sender keeps offering
    reconfigure(11'd4, 11'd4, 11'd4, 11'd1, 11'd1, 11'd1, 11'd1, 1'b0);
    hold_requests++;
    stream_samples(64, 1'b0);

    // One of width, height or channel count driven past its limit
    case ($urandom_range(2))
      0: begin
        set_idling(IDLE_BOTH);
        reconfigure(11'h7FF, 11'd1, 11'd2, 11'd1, 11'd1, 11'd1, 11'd1, 1'b0);
        stream_samples(MAP_W_MAX + 6, 1'b0);
      end
      1: begin
        set_idling(IDLE_SENDER);
        reconfigure(11'd1, 11'h7FF, 11'd2, 11'd1, 11'd1, 11'd1, 11'd1, 1'b0);
        stream_samples(MAP_H_MAX + 6, 1'b0);
      end
      default: begin
        set_idling(IDLE_RECEIVER);
        reconfigure(11'd1, 11'd1, 11'h7FF, 11'd1, 11'd1, 11'd1, 11'd1, 1'b0);
        stream_samples(CHAN_MAX + 6, 1'b0);
      end
    endcase

    // Random geometries, mostly whole map sets
    phase = 0;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      set_idling(idle_mode_t'(phase % 4));
      kmax = ($urandom_range(3) == 0) ? KERN_MAX : 3;
      reconfigure(pick_reg(1, 12, 1'b0), pick_reg(1, 10, 1'b0), pick_reg(1, 3, 1'b0),
                  pick_reg(1, kmax, 1'b1), pick_reg(1, kmax, 1'b1),
                  pick_reg(1, kmax, 1'b1), pick_reg(1, kmax, 1'b1),
                  $urandom_range(7) == 0);
      set_size = map_set_size();
      case ($urandom_range(4))
        0: items = $urandom_range(set_size, 1);
        1: items = 2 * set_size;
        default: items = set_size;
      endcase
      stream_samples(items, phase % 5 == 2);
      total += items;
      phase++;
    end

    // Drain and finish
    in_valid <= 1'b0;
    do @(posedge clk); while (pooled_q.size() != 0);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
